[rtl/core/semaphore_wait_queue_table_assert.svh]
// Assertion macros used by the datapath of the semaphore wait queue table.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef SEMAPHORE_WAIT_QUEUE_TABLE_ASSERT_SVH
`define SEMAPHORE_WAIT_QUEUE_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWQT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWQT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/swqt_pkg.sv]
package swqt_pkg;

    localparam logic [1:0] CMD_BLOCK  = 2'd0;
    localparam logic [1:0] CMD_WAKE   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_PEEK   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFREE   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_BLOCKED  = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] sem_key;
        logic [4:0]  proc_id;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic       has_proc;
        logic [4:0] proc_out;
    } rsp_word_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_WKEY,
        OP_SCAN,
        OP_HEAD,
        OP_ALLOC,
        OP_APPEND,
        OP_APPEND2,
        OP_UNLINK,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] status;
    } dp_ctrl_t;

    typedef struct packed {
        logic [1:0] command;
        logic       key_zero;
        logic       p_ok;
        logic       p_queued;
        logic       scan_done;
        logic       found;
        logic       free_ok;
        logic       out_free;
    } dp_stat_t;

endpackage

[rtl/core/swqt_datapath.sv]
`include "semaphore_wait_queue_table_assert.svh"

module swqt_datapath #(
    parameter int MAX_PROCESSES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  swqt_pkg::cmd_word_t cmd_word,
    input  swqt_pkg::dp_ctrl_t ctrl,
    output swqt_pkg::dp_stat_t stat,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output swqt_pkg::rsp_word_t rsp_word
);

    localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int SW = $clog2(MAX_PROCESSES + 1);

    // Descriptor and process stores.
    logic [31:0]   key_mem  [MAX_PROCESSES];
    logic [IW-1:0] head_mem [MAX_PROCESSES];
    logic [IW-1:0] tail_mem [MAX_PROCESSES];
    logic [IW-1:0] next_mem [MAX_PROCESSES];
    logic [IW-1:0] prev_mem [MAX_PROCESSES];
    logic [31:0]   wkey_mem [MAX_PROCESSES];

    logic [31:0]   key_rd_reg;
    logic [IW-1:0] head_rd_reg;
    logic [IW-1:0] tail_rd_reg;
    logic [IW-1:0] next_rd_reg;
    logic [IW-1:0] prev_rd_reg;
    logic [31:0]   wkey_rd_reg;

    logic [31:0]   key_reg;
    logic [IW-1:0] p_reg;

    logic [1:0]    cmd_reg;
    logic          key_zero_reg;
    logic          p_ok_reg;
    logic [SW-1:0] scan_cnt_reg;
    logic          cmp_valid_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          found_reg;
    logic [IW-1:0] d_reg;
    logic          free_ok_reg;
    logic [IW-1:0] free_reg;
    logic [MAX_PROCESSES-1:0] active_reg;
    logic [MAX_PROCESSES-1:0] queued_reg;
    logic          out_valid_reg;
    swqt_pkg::rsp_word_t out_word_reg;

    logic [IW-1:0] scan_addr;
    logic          is_head;
    logic          is_tail;
    logic          scan_more;
    logic          has_next;

    assign scan_addr = scan_cnt_reg[IW-1:0];
    assign scan_more = (32'(scan_cnt_reg) < 32'(MAX_PROCESSES));
    assign is_head   = (head_rd_reg == p_reg);
    assign is_tail   = (tail_rd_reg == p_reg);
    assign has_next  = (ctrl.status == swqt_pkg::ST_OK) && (cmd_reg != swqt_pkg::CMD_BLOCK);

    always_ff @(posedge clk)
    begin
        key_rd_reg  <= key_mem[scan_addr];
        head_rd_reg <= head_mem[d_reg];
        tail_rd_reg <= tail_mem[d_reg];
        next_rd_reg <= next_mem[p_reg];
        prev_rd_reg <= prev_mem[p_reg];
        wkey_rd_reg <= wkey_mem[p_reg];

        unique case (ctrl.op)
            swqt_pkg::OP_LATCH:
            begin
                key_reg <= cmd_word.sem_key;
                p_reg   <= IW'(cmd_word.proc_id);
            end
            swqt_pkg::OP_WKEY:
            begin
                key_reg <= wkey_rd_reg;
            end
            swqt_pkg::OP_HEAD:
            begin
                p_reg <= head_rd_reg;
            end
            swqt_pkg::OP_ALLOC:
            begin
                key_mem[free_reg]  <= key_reg;
                head_mem[free_reg] <= p_reg;
                tail_mem[free_reg] <= p_reg;
                prev_mem[p_reg]    <= p_reg;
                next_mem[p_reg]    <= p_reg;
                wkey_mem[p_reg]    <= key_reg;
            end
            swqt_pkg::OP_APPEND:
            begin
                next_mem[tail_rd_reg] <= p_reg;
                prev_mem[p_reg]       <= tail_rd_reg;
                tail_mem[d_reg]       <= p_reg;
                wkey_mem[p_reg]       <= key_reg;
            end
            swqt_pkg::OP_APPEND2:
            begin
                next_mem[p_reg] <= p_reg;
            end
            swqt_pkg::OP_UNLINK:
            begin
                if (is_head && !is_tail)
                begin
                    head_mem[d_reg] <= next_rd_reg;
                end
                else if (is_tail && !is_head)
                begin
                    tail_mem[d_reg] <= prev_rd_reg;
                end
                else if (!is_head && !is_tail)
                begin
                    next_mem[prev_rd_reg] <= next_rd_reg;
                    prev_mem[next_rd_reg] <= prev_rd_reg;
                end
                if (cmd_reg == swqt_pkg::CMD_WAKE)
                begin
                    wkey_mem[p_reg] <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= '0;
            key_zero_reg  <= 1'b0;
            p_ok_reg      <= 1'b0;
            scan_cnt_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            found_reg     <= 1'b0;
            d_reg         <= '0;
            free_ok_reg   <= 1'b0;
            free_reg      <= '0;
            active_reg    <= '0;
            queued_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            if (cmp_valid_reg)
            begin
                if (active_reg[cmp_idx_reg] && key_rd_reg == key_reg && !found_reg)
                begin
                    found_reg <= 1'b1;
                    d_reg     <= cmp_idx_reg;
                end
                if (!active_reg[cmp_idx_reg] && !free_ok_reg)
                begin
                    free_ok_reg <= 1'b1;
                    free_reg    <= cmp_idx_reg;
                end
            end
            // A new response fills the register; otherwise it empties once taken.
            if (ctrl.op == swqt_pkg::OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (ctrl.op)
                swqt_pkg::OP_LATCH:
                begin
                    cmd_reg       <= cmd_word.command;
                    key_zero_reg  <= (cmd_word.sem_key == 32'd0);
                    p_ok_reg      <= (32'(cmd_word.proc_id) < 32'(MAX_PROCESSES));
                    scan_cnt_reg  <= '0;
                    cmp_valid_reg <= 1'b0;
                    found_reg     <= 1'b0;
                    free_ok_reg   <= 1'b0;
                end
                swqt_pkg::OP_SCAN:
                begin
                    if (scan_more)
                    begin
                        cmp_valid_reg <= 1'b1;
                        cmp_idx_reg   <= scan_addr;
                        scan_cnt_reg  <= scan_cnt_reg + SW'(1);
                    end
                    else
                    begin
                        cmp_valid_reg <= 1'b0;
                    end
                end
                swqt_pkg::OP_ALLOC:
                begin
                    active_reg[free_reg] <= 1'b1;
                    queued_reg[p_reg]    <= 1'b1;
                end
                swqt_pkg::OP_APPEND:
                begin
                    queued_reg[p_reg] <= 1'b1;
                end
                swqt_pkg::OP_UNLINK:
                begin
                    if (is_head && is_tail)
                    begin
                        active_reg[d_reg] <= 1'b0;
                    end
                    queued_reg[p_reg] <= 1'b0;
                end
                swqt_pkg::OP_RESULT:
                begin
                    out_word_reg.status   <= ctrl.status;
                    out_word_reg.has_proc <= has_next;
                    if (!has_next)
                    begin
                        out_word_reg.proc_out <= '0;
                    end
                    else if (cmd_reg == swqt_pkg::CMD_PEEK)
                    begin
                        out_word_reg.proc_out <= 5'(head_rd_reg);
                    end
                    else
                    begin
                        out_word_reg.proc_out <= 5'(p_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.command   = cmd_reg;
    assign stat.key_zero  = key_zero_reg;
    assign stat.p_ok      = p_ok_reg;
    assign stat.p_queued  = queued_reg[p_reg];
    assign stat.scan_done = !cmp_valid_reg && !scan_more;
    assign stat.found     = found_reg;
    assign stat.free_ok   = free_ok_reg;
    assign stat.out_free  = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    `SWQT_ASSERT_NOW(a_has_ok, out_valid_reg && out_word_reg.has_proc,
        out_word_reg.status == swqt_pkg::ST_OK, "returned process without ok status")
    `SWQT_ASSERT_NOW(a_noproc_zero, out_valid_reg && !out_word_reg.has_proc,
        out_word_reg.proc_out == 5'd0, "proc_out nonzero without a process")
    `SWQT_ASSERT_NOW(a_alloc_free, ctrl.op == swqt_pkg::OP_ALLOC,
        !active_reg[free_reg] && !queued_reg[p_reg],
        "allocation onto a busy descriptor or queued process")
    `SWQT_ASSERT_NOW(a_unlink_queued, ctrl.op == swqt_pkg::OP_UNLINK,
        queued_reg[p_reg] && active_reg[d_reg], "unlink of a process that is not queued")
    `SWQT_ASSERT_NEXT(a_result_valid, ctrl.op == swqt_pkg::OP_RESULT,
        out_valid_reg, "result not registered")

endmodule

[rtl/core/swqt_ctrl.sv]
module swqt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  swqt_pkg::dp_stat_t stat,
    output swqt_pkg::dp_ctrl_t ctrl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_WKEY,
        S_SCAN,
        S_RD,
        S_HEAD,
        S_RD2,
        S_ALLOC,
        S_APPEND,
        S_APPEND2,
        S_UNLINK,
        S_FIN
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;
    logic       accept;

    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        ctrl.op     = swqt_pkg::OP_NONE;
        ctrl.status = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.op    = swqt_pkg::OP_LATCH;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next  = S_FIN;
                status_next = swqt_pkg::ST_NOTFOUND;
                unique case (stat.command)
                    swqt_pkg::CMD_BLOCK:
                    begin
                        if (!stat.key_zero && stat.p_ok)
                        begin
                            if (stat.p_queued)
                            begin
                                status_next = swqt_pkg::ST_BLOCKED;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                    end
                    swqt_pkg::CMD_REMOVE:
                    begin
                        if (stat.p_ok && stat.p_queued)
                        begin
                            state_next = S_WKEY;
                        end
                    end
                    default:
                    begin
                        if (!stat.key_zero)
                        begin
                            state_next = S_SCAN;
                        end
                    end
                endcase
            end
            S_WKEY:
            begin
                ctrl.op    = swqt_pkg::OP_WKEY;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                ctrl.op = swqt_pkg::OP_SCAN;
                if (stat.scan_done)
                begin
                    if (stat.found)
                    begin
                        state_next = S_RD;
                    end
                    else if (stat.command == swqt_pkg::CMD_BLOCK && stat.free_ok)
                    begin
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        state_next  = S_FIN;
                        status_next = (stat.command == swqt_pkg::CMD_BLOCK) ?
                                      swqt_pkg::ST_NOFREE : swqt_pkg::ST_NOTFOUND;
                    end
                end
            end
            S_RD:
            begin
                unique case (stat.command)
                    swqt_pkg::CMD_BLOCK:  state_next = S_APPEND;
                    swqt_pkg::CMD_WAKE:   state_next = S_HEAD;
                    swqt_pkg::CMD_REMOVE: state_next = S_UNLINK;
                    default:
                    begin
                        state_next  = S_FIN;
                        status_next = swqt_pkg::ST_OK;
                    end
                endcase
            end
            S_HEAD:
            begin
                ctrl.op    = swqt_pkg::OP_HEAD;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                state_next = S_UNLINK;
            end
            S_ALLOC:
            begin
                ctrl.op     = swqt_pkg::OP_ALLOC;
                state_next  = S_FIN;
                status_next = swqt_pkg::ST_OK;
            end
            S_APPEND:
            begin
                ctrl.op    = swqt_pkg::OP_APPEND;
                state_next = S_APPEND2;
            end
            S_APPEND2:
            begin
                ctrl.op     = swqt_pkg::OP_APPEND2;
                state_next  = S_FIN;
                status_next = swqt_pkg::ST_OK;
            end
            S_UNLINK:
            begin
                ctrl.op     = swqt_pkg::OP_UNLINK;
                state_next  = S_FIN;
                status_next = swqt_pkg::ST_OK;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = swqt_pkg::OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= swqt_pkg::ST_NOTFOUND;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

[rtl/core/semaphore_wait_queue_table.sv]
// Channel  | Handshake              | Word
// ---------+------------------------+-----------------------------------
// command  | cmd_valid, cmd_stall   | cmd_word: command, sem_key, proc_id
// response | rsp_valid, rsp_stall   | rsp_word: status, has_proc, proc_out
//
// One command word is worked on at a time; one rejected at the first check
// goes straight to its response, with no descriptor scan.
// The descriptor scan is sequential, one key store read per cycle.
// Reset clears the active and queued marks at once; no clearing pass is needed.
// A finished response waits in the output register while the next word is taken.

module semaphore_wait_queue_table #(
    parameter int MAX_PROCESSES = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  swqt_pkg::cmd_word_t cmd_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output swqt_pkg::rsp_word_t rsp_word
);

    // The controller sequences each command: check, optional waiting key fetch,
    // descriptor scan, link reads and link writes as the command needs, then the result.
    swqt_pkg::dp_ctrl_t ctrl;
    // The datapath reports the latched command, scan outcome and flags.
    swqt_pkg::dp_stat_t stat;

    swqt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // The datapath owns the descriptor and process stores, the scan
    // pipeline and the output register that holds one response word.
    swqt_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd_word),
        .ctrl      (ctrl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule
